[sv/fsc_pkg.sv]
// Shared types, order codes and the per-position judge function for the fuzzy string compare.
package fsc_pkg;

    typedef logic signed [1:0] order_t;

    localparam order_t ORDER_LESS    = 2'sb11;
    localparam order_t ORDER_EQUAL   = 2'sb00;
    localparam order_t ORDER_GREATER = 2'sb01;

    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       final_pair;
    } pair_t;

    typedef struct packed {
        logic   valid;
        order_t order;
    } result_t;

    typedef struct packed {
        order_t order;
        logic   skip;
    } verdict_t;

    // Judge one position against its next and previous neighbors.
    function automatic verdict_t judge(
        input logic [7:0] a,
        input logic [7:0] b,
        input logic       has_next,
        input logic [7:0] na,
        input logic [7:0] nb,
        input logic       has_prev,
        input logic [7:0] pa,
        input logic [7:0] pb
    );
        verdict_t v;
        v.skip  = 1'b0;
        v.order = ORDER_EQUAL;
        if (a == b)
        begin
            v.order = ORDER_EQUAL;
        end
        else if (has_next && (na == nb))
        begin
            v.skip  = 1'b1;
            v.order = ORDER_EQUAL;
        end
        else if (has_next && ((a == nb) || (na == b)))
        begin
            v.order = ORDER_EQUAL;
        end
        else if (has_prev && ((a == pb) || (pa == b)))
        begin
            v.order = ORDER_EQUAL;
        end
        else
        begin
            v.order = (a < b) ? ORDER_LESS : ORDER_GREATER;
        end
        return v;
    endfunction

endpackage

[sv/fsc_core.sv]
// Held-pair state and the decision logic for one registered byte pair per cycle in which fire is high.
module fsc_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  fsc_pkg::pair_t pair,
    output fsc_pkg::result_t result
);

    logic [7:0] held_first_reg;
    logic [7:0] held_second_reg;
    logic [7:0] prior_first_reg;
    logic [7:0] prior_second_reg;
    logic       held_valid_reg;
    logic       skip_next_reg;
    logic       have_prior_reg;
    logic       decided_reg;

    logic [7:0] held_first_next;
    logic [7:0] held_second_next;
    logic [7:0] prior_first_next;
    logic [7:0] prior_second_next;
    logic       held_valid_next;
    logic       skip_next_next;
    logic       have_prior_next;
    logic       decided_next;

    fsc_pkg::verdict_t alone_v;
    fsc_pkg::verdict_t held_v;
    fsc_pkg::verdict_t last_v;
    fsc_pkg::order_t   held_order;

    // Single-pair string, held pair against the new one, and the new pair as the last one.
    assign alone_v = fsc_pkg::judge(pair.first_byte, pair.second_byte, 1'b0, 8'd0, 8'd0,
                                    1'b0, 8'd0, 8'd0);
    assign held_v  = fsc_pkg::judge(held_first_reg, held_second_reg, 1'b1,
                                    pair.first_byte, pair.second_byte,
                                    have_prior_reg, prior_first_reg, prior_second_reg);
    assign last_v  = fsc_pkg::judge(pair.first_byte, pair.second_byte, 1'b0, 8'd0, 8'd0,
                                    1'b1, held_first_reg, held_second_reg);
    assign held_order = skip_next_reg ? fsc_pkg::ORDER_EQUAL : held_v.order;

    always_comb
    begin
        held_first_next   = held_first_reg;
        held_second_next  = held_second_reg;
        prior_first_next  = prior_first_reg;
        prior_second_next = prior_second_reg;
        held_valid_next   = held_valid_reg;
        skip_next_next    = skip_next_reg;
        have_prior_next   = have_prior_reg;
        decided_next      = decided_reg;
        result.valid      = 1'b0;
        result.order      = fsc_pkg::ORDER_EQUAL;

        if (decided_reg)
        begin
            // Drop pairs until the string ends.
            if (pair.final_pair)
            begin
                decided_next    = 1'b0;
                held_valid_next = 1'b0;
                skip_next_next  = 1'b0;
                have_prior_next = 1'b0;
            end
        end
        else if (!held_valid_reg)
        begin
            if (pair.final_pair)
            begin
                result.valid = 1'b1;
                result.order = alone_v.order;
            end
            else
            begin
                held_first_next  = pair.first_byte;
                held_second_next = pair.second_byte;
                held_valid_next  = 1'b1;
            end
        end
        else if (held_order != fsc_pkg::ORDER_EQUAL)
        begin
            result.valid = 1'b1;
            result.order = held_order;
            if (pair.final_pair)
            begin
                held_valid_next = 1'b0;
                skip_next_next  = 1'b0;
                have_prior_next = 1'b0;
            end
            else
            begin
                decided_next = 1'b1;
            end
        end
        else
        begin
            // Advance the window by one position.
            prior_first_next  = held_first_reg;
            prior_second_next = held_second_reg;
            have_prior_next   = 1'b1;
            held_first_next   = pair.first_byte;
            held_second_next  = pair.second_byte;
            skip_next_next    = !skip_next_reg && held_v.skip;
            if (pair.final_pair)
            begin
                result.valid    = 1'b1;
                result.order    = (!skip_next_reg && held_v.skip) ? fsc_pkg::ORDER_EQUAL
                                                                  : last_v.order;
                held_valid_next = 1'b0;
                skip_next_next  = 1'b0;
                have_prior_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_first_reg   <= 8'd0;
            held_second_reg  <= 8'd0;
            prior_first_reg  <= 8'd0;
            prior_second_reg <= 8'd0;
            held_valid_reg   <= 1'b0;
            skip_next_reg    <= 1'b0;
            have_prior_reg   <= 1'b0;
            decided_reg      <= 1'b0;
        end
        else if (fire)
        begin
            held_first_reg   <= held_first_next;
            held_second_reg  <= held_second_next;
            prior_first_reg  <= prior_first_next;
            prior_second_reg <= prior_second_next;
            held_valid_reg   <= held_valid_next;
            skip_next_reg    <= skip_next_next;
            have_prior_reg   <= have_prior_next;
            decided_reg      <= decided_next;
        end
    end

    a_decided_held: assert property (@(posedge clk) disable iff (!rst_n)
        decided_reg |-> held_valid_reg)
        else $error("decided set without a held pair");

    a_skip_prior: assert property (@(posedge clk) disable iff (!rst_n)
        skip_next_reg |-> (held_valid_reg && have_prior_reg))
        else $error("skip pending without a prior position");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && pair.final_pair) |=> (!held_valid_reg && !decided_reg))
        else $error("state not cleared after final pair");

endmodule

[sv/fuzzy_string_compare_top.sv]
// Top level of the fuzzy string compare: input register, decision core and result register.
//
// Usage: feed both strings one aligned byte pair per transfer on the input
// channel (first_byte, second_byte, final_pair); mark the last position with
// final_pair. Each string gives exactly one transfer on the output channel:
// order is -1 or 1 at the first failing position, or 0 at the final pair.
// Pairs after a failure are consumed without result up to the final pair.
// Both channels use valid/stall; a transfer happens when valid is high and
// stall is low.
// A result is registered twice: the pair that decides it enters the input
// register, then its decision enters the result register, from which it
// leaves. Throughput: one pair per cycle while the receiver does not stall,
// as the new pair is compared combinationally against the held and prior pairs.
// Reset clears all held pairs and flags; the next pair starts a new string.
// When the receiver stalls with a result pending, the result is held and
// the input register fills, after which in_stall rises until it drains.
module fuzzy_string_compare_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           first_byte,
    input  logic [7:0]           second_byte,
    input  logic                 final_pair,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [1:0]    order
);

    fsc_pkg::pair_t   pair_reg;
    logic             in_valid_reg;
    fsc_pkg::result_t result;
    logic             out_valid_reg;
    fsc_pkg::order_t  order_reg;
    logic             out_free;
    logic             fire;

    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Load the payload on each input transfer.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            pair_reg.first_byte  <= first_byte;
            pair_reg.second_byte <= second_byte;
            pair_reg.final_pair  <= final_pair;
        end
    end

    fsc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .pair   (pair_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= fire && result.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            order_reg <= result.order;
        end
    end

    assign out_valid = out_valid_reg;
    assign order     = order_reg;

    a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_free) |=> in_valid_reg)
        else $error("pending pair lost while output blocked");

    a_order_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (order_reg != 2'sb10))
        else $error("invalid order code on output");

    a_no_fire_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !fire)
        else $error("pair processed while result register blocked");

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the fuzzy string compare, with a pair-level order predictor.
module testbench;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int TARGET_PAIRS = 1950;
    localparam int SETTLE       = 10;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [7:0]       first_byte;
    logic [7:0]       second_byte;
    logic             final_pair;
    logic             out_valid;
    logic             out_stall;
    logic signed [1:0] order;

    fuzzy_string_compare_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .first_byte  (first_byte),
        .second_byte (second_byte),
        .final_pair  (final_pair),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .order       (order)
    );

    // Predicts the order each string yields and holds the orders still due.
    class order_scoreboard;
        logic [7:0]       held_a;
        logic [7:0]       held_b;
        logic [7:0]       prev_a;
        logic [7:0]       prev_b;
        logic             holding;
        logic             skip_held;
        logic             has_prev;
        logic             failed;
        fsc_pkg::order_t  due_orders[$];
        int               errors;

        function new();
            clear();
            errors = 0;
        endfunction

        function void clear();
            held_a    = 8'h00;
            held_b    = 8'h00;
            prev_a    = 8'h00;
            prev_b    = 8'h00;
            holding   = 1'b0;
            skip_held = 1'b0;
            has_prev  = 1'b0;
            failed    = 1'b0;
        endfunction

        // Rank one position against its neighbors; flag a look-ahead pass.
        function fsc_pkg::order_t rank(input logic [7:0] a, input logic [7:0] b,
                                       input logic with_next, input logic [7:0] na,
                                       input logic [7:0] nb, input logic with_prev,
                                       input logic [7:0] pa, input logic [7:0] pb,
                                       output logic skip);
            skip = 1'b0;
            if (a == b)
                return fsc_pkg::ORDER_EQUAL;
            if (with_next && na == nb)
            begin
                skip = 1'b1;
                return fsc_pkg::ORDER_EQUAL;
            end
            if (with_next && (a == nb || na == b))
                return fsc_pkg::ORDER_EQUAL;
            if (with_prev && (a == pb || pa == b))
                return fsc_pkg::ORDER_EQUAL;
            return (a < b) ? fsc_pkg::ORDER_LESS : fsc_pkg::ORDER_GREATER;
        endfunction

        function void note_pair(input logic [7:0] a, input logic [7:0] b, input logic fin);
            logic            skip;
            fsc_pkg::order_t r;
            skip = 1'b0;
            r    = fsc_pkg::ORDER_EQUAL;
            if (failed)
            begin
                if (fin)
                    clear();
                return;
            end
            if (!holding)
            begin
                if (fin)
                begin
                    r = rank(a, b, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, skip);
                    clear();
                    due_orders.push_back(r);
                end
                else
                begin
                    held_a  = a;
                    held_b  = b;
                    holding = 1'b1;
                end
                return;
            end
            if (skip_held)
                skip_held = 1'b0;
            else
                r = rank(held_a, held_b, 1'b1, a, b, has_prev, prev_a, prev_b, skip);
            if (r != fsc_pkg::ORDER_EQUAL)
            begin
                due_orders.push_back(r);
                if (fin)
                    clear();
                else
                    failed = 1'b1;
                return;
            end
            prev_a    = held_a;
            prev_b    = held_b;
            has_prev  = 1'b1;
            held_a    = a;
            held_b    = b;
            skip_held = skip;
            if (fin)
            begin
                if (!skip_held)
                    r = rank(held_a, held_b, 1'b0, 8'h00, 8'h00, 1'b1, prev_a, prev_b, skip);
                clear();
                due_orders.push_back(r);
            end
        endfunction

        task report(input string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_order(input fsc_pkg::order_t got);
            fsc_pkg::order_t want;
            if (due_orders.size() == 0)
            begin
                report($sformatf("order %0d with none due", got));
                return;
            end
            want = due_orders.pop_front();
            if (got !== want)
                report($sformatf("order got %0d, want %0d", got, want));
        endtask

        function int pending();
            return due_orders.size();
        endfunction
    endclass

    order_scoreboard sb;
    logic [7:0]      first_q[$];
    logic [7:0]      second_q[$];
    int              burst_left;
    int              pairs_sent;
    int              cycle_count;
    int              stall_mode;
    int              stall_left;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_order(order);
    end

    // Receiver stall: switch between pattern modes every so often.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ((stall_left % 5) < 2);
        endcase
    end

    task automatic send_pair(input logic [7:0] a, input logic [7:0] b, input logic fin);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 20);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid    <= 1'b1;
        first_byte  <= a;
        second_byte <= b;
        final_pair  <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_pair(a, b, fin);
        pairs_sent++;
    endtask

    task automatic send_string();
        for (int i = 0; i < first_q.size(); i++)
            send_pair(first_q[i], second_q[i], i == first_q.size() - 1);
    endtask

    // Hold the sender until every due order has come back.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        burst_left = 0;
    endtask

    task automatic build_string();
        int len;
        int style;
        int pos;
        int edits;
        logic [7:0] tmp;
        len   = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        style = $urandom_range(0, 19);
        first_q.delete();
        second_q.delete();
        for (int i = 0; i < len; i++)
        begin
            if (style < 8)
            begin
                // tiny alphabet: lots of neighbor matches and slips
                first_q.push_back(8'(8'h61 + $urandom_range(0, 3)));
                second_q.push_back(8'(8'h61 + $urandom_range(0, 3)));
            end
            else
            begin
                first_q.push_back(8'($urandom_range(0, 255)));
                second_q.push_back(8'($urandom_range(0, 255)));
            end
        end
        if (style >= 8 && style < 15)
        begin
            // near copy: a few substitutions and adjacent swaps
            second_q = first_q;
            edits = $urandom_range(0, 3);
            repeat (edits)
            begin
                pos = $urandom_range(0, len - 1);
                if (len > 1 && $urandom_range(0, 1) == 1 && pos < len - 1)
                begin
                    tmp               = second_q[pos];
                    second_q[pos]     = second_q[pos + 1];
                    second_q[pos + 1] = tmp;
                end
                else
                begin
                    second_q[pos] = 8'($urandom_range(0, 255));
                end
            end
        end
    endtask

    initial
    begin
        sb          = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        first_byte  = 8'h00;
        second_byte = 8'h00;
        final_pair  = 1'b0;
        out_stall   = 1'b0;
        burst_left  = 0;
        pairs_sent  = 0;
        cycle_count = 0;
        stall_mode  = 0;
        stall_left  = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // single pair strings: equal, higher, lower
        first_q = '{8'h00};  second_q = '{8'h00};  send_string();
        first_q = '{8'hFF};  second_q = '{8'h00};  send_string();
        first_q = '{8'h00};  second_q = '{8'hFF};  send_string();
        // adjacent swap, final passes on the previous neighbor
        first_q = '{"a", "b"};  second_q = '{"b", "a"};  send_string();
        // look-ahead skip lands on the final pair
        first_q = '{8'hFF, 8'hFF};  second_q = '{8'hFE, 8'hFF};  send_string();
        // look-ahead skip, then failure on the final pair
        first_q = '{"x", "k", "A"};  second_q = '{"y", "k", "B"};  send_string();
        // early failure, trailing pairs dropped up to the final one
        first_q = '{"m", "A", "z", "z", "z"};  second_q = '{"n", "B", "q", "q", "q"};
        send_string();
        // pass on previous neighbor mid-string, fail on the final pair
        first_q = '{"a", "b", "c"};  second_q = '{"x", "a", "z"};  send_string();
        drain();

        while (pairs_sent < TARGET_PAIRS)
        begin
            build_string();
            send_string();
            if ($urandom_range(0, 39) == 0)
                drain();
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

[filelist.f]
sv/fsc_pkg.sv
sv/fsc_core.sv
sv/fuzzy_string_compare_top.sv
test/testbench.sv
